FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared types and constants for the list cells and the top level.
// ----------------------------------------------------------------------------
package ple_pkg;

  // Default number of list entries.
  localparam int unsigned PleCapacity = 16;

  // Width of a list index inside the cell row; covers the largest capacity.
  localparam int unsigned PleIdxW = 9;

  localparam int unsigned PleWordW = 32;

  typedef enum logic [1:0] {
    OpInsert     = 2'd0,
    OpRemoveAt   = 2'd1,
    OpRemoveLast = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Broadcast from the control to every cell of the row.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [PleIdxW-1:0] pos;
  } cell_ctrl_t;

endpackage

FILE: rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry and shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned INDEX = 0
) (
  input  logic                clk_i,
  input  cell_ctrl_t          ctrl_i,
  input  logic [PleWordW-1:0] write_value_i,
  input  logic [PleWordW-1:0] lower_word_i,
  input  logic [PleWordW-1:0] upper_word_i,
  output logic [PleWordW-1:0] word_o,
  output logic [PleWordW-1:0] read_o
);

  localparam logic [PleIdxW-1:0] MyIdx = PleIdxW'(INDEX);

  logic [PleWordW-1:0] word_q, word_d;
  logic                hit;

  assign hit = (ctrl_i.pos == MyIdx);

  always_comb begin
    word_d = word_q;
    if (ctrl_i.ins) begin
      if (hit) begin
        word_d = write_value_i;
      end else if (MyIdx > ctrl_i.pos) begin
        word_d = lower_word_i;
      end
    end else if (ctrl_i.rem && (MyIdx >= ctrl_i.pos)) begin
      word_d = upper_word_i;
    end
  end

  // Entries carry no reset; only slots below the count are ever read.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign read_o = hit ? word_q : '0;

endmodule

FILE: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// The result strobe rises in the cycle after the request is taken.
// Throughput: one request per cycle; every cell shifts in parallel, busy_o stays low.
// Reset clears the entry count and the result strobe; entries are not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY = PleCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  position_i,
  input  logic [31:0] write_value_i,
  output logic        done_o,
  output logic [31:0] removed_value_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic [CntW-1:0]     count_q, count_d;
  logic                done_q;
  logic [31:0]         removed_q, removed_d;
  status_e             status_q, status_d;
  cell_ctrl_t          ctrl;
  logic [PleIdxW-1:0]  count_ix, pos_ix;
  logic [PleWordW-1:0] words [CAPACITY];
  logic [PleWordW-1:0] reads [CAPACITY];
  logic [PleWordW-1:0] read_word;

  assign count_ix = PleIdxW'(count_q);
  assign pos_ix   = PleIdxW'(position_i);

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = StDone;
    if (start_i) begin
      unique case (opcode_e'(opcode_i))
        OpInsert: begin
          if (count_q >= CapCnt) begin
            status_d = StFull;
          end else begin
            ctrl.ins = 1'b1;
            ctrl.pos = (pos_ix < count_ix) ? pos_ix : count_ix;
            count_d  = count_q + CntW'(1);
          end
        end
        OpRemoveAt: begin
          if (pos_ix < count_ix) begin
            ctrl.rem = 1'b1;
            ctrl.pos = pos_ix;
            count_d  = count_q - CntW'(1);
          end else begin
            status_d = StEmpty;
          end
        end
        OpRemoveLast: begin
          if (count_q != '0) begin
            ctrl.rem = 1'b1;
            ctrl.pos = count_ix - PleIdxW'(1);
            count_d  = count_q - CntW'(1);
          end else begin
            status_d = StEmpty;
          end
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [PleWordW-1:0] lower_word, upper_word;
    if (i == 0) begin : g_first
      assign lower_word = '0;
    end else begin : g_inner_lo
      assign lower_word = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_word = '0;
    end else begin : g_inner_hi
      assign upper_word = words[i+1];
    end
    ple_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .write_value_i (write_value_i),
      .lower_word_i  (lower_word),
      .upper_word_i  (upper_word),
      .word_o        (words[i]),
      .read_o        (reads[i])
    );
  end

  // Only the addressed cell drives a nonzero read word, so an OR selects it.
  always_comb begin
    read_word = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      read_word = read_word | reads[k];
    end
  end

  assign removed_d = ctrl.rem ? read_word : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  assign busy_o          = 1'b0;
  assign done_o          = done_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign entry_count_o   = 5'(count_q);

`ifndef SYNTH
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_o)
    else $error("result strobe missing after a request");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> !done_o)
    else $error("result strobe without a request");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count exceeds capacity");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == StFull)) |-> (count_q == CapCnt))
    else $error("insert dropped while list not full");
`endif

endmodule

FILE: tb/positional_list_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert and remove requests through the start/busy handshake, keeps a
// queue-based copy of the list, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
  import ple_pkg::*;

  localparam int unsigned Capacity  = PleCapacity;
  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned NumPhases = 24;
  localparam int unsigned PhaseLen  = 64;

  typedef struct packed {
    logic [31:0] removed;
    status_e     status;
    logic [4:0]  count;
  } list_result_t;

  typedef struct {
    opcode_e      op;
    logic [4:0]   pos;
    logic [31:0]  val;
    bit           typed;
    list_result_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  opcode_i = OpInsert;
  logic [4:0]  position_i = '0;
  logic [31:0] write_value_i = '0;
  logic        done_o;
  logic [31:0] removed_value_o;
  logic [1:0]  status_o;
  logic [4:0]  entry_count_o;

  logic [31:0]  shadow_list[$];
  list_result_t pending_results[$];
  plan_row_t    plan[$];
  int unsigned  error_count = 0;
  int unsigned  results_seen = 0;
  int unsigned  inserts_done = 0;
  int unsigned  removes_done = 0;
  int unsigned  full_drops = 0;
  int unsigned  empty_removes = 0;
  int unsigned  peak_fill_hits = 0;

  positional_list_engine #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .position_i     (position_i),
    .write_value_i  (write_value_i),
    .done_o         (done_o),
    .removed_value_o(removed_value_o),
    .status_o       (status_o),
    .entry_count_o  (entry_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Applies one request to the shadow list and returns the result it should give.
  function automatic list_result_t apply_request(opcode_e op, logic [4:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int unsigned  at;
    r = '0;
    r.status = StDone;
    case (op)
      OpInsert: begin
        if (shadow_list.size() >= Capacity) begin
          r.status = StFull;
          full_drops++;
        end else begin
          at = (pos < shadow_list.size()) ? pos : shadow_list.size();
          shadow_list.insert(at, val);
          inserts_done++;
          if (shadow_list.size() == Capacity) peak_fill_hits++;
        end
      end
      OpRemoveAt: begin
        if (pos < shadow_list.size()) begin
          r.removed = shadow_list[pos];
          shadow_list.delete(pos);
          removes_done++;
        end else begin
          r.status = StEmpty;
          empty_removes++;
        end
      end
      OpRemoveLast: begin
        if (shadow_list.size() > 0) begin
          r.removed = shadow_list[shadow_list.size() - 1];
          shadow_list.delete(shadow_list.size() - 1);
          removes_done++;
        end else begin
          r.status = StEmpty;
          empty_removes++;
        end
      end
      default: ;
    endcase
    r.count = 5'(shadow_list.size());
    return r;
  endfunction

  task automatic add_row(opcode_e op, logic [4:0] pos, logic [31:0] val, bit typed,
                         logic [31:0] removed, status_e status, logic [4:0] count);
    plan_row_t row;
    row.op = op;
    row.pos = pos;
    row.val = val;
    row.typed = typed;
    row.want.removed = removed;
    row.want.status = status;
    row.want.count = count;
    plan.insert(plan.size(), row);
  endtask

  // Presents one request after an idle gap, if any, and waits for its transfer.
  task automatic send_request(opcode_e op, logic [4:0] pos, logic [31:0] val,
                              int unsigned gap, bit typed, list_result_t want);
    list_result_t predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      opcode_i <= 2'($urandom_range(0, 2));
      position_i <= 5'($urandom);
      write_value_i <= $urandom;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    opcode_i <= op;
    position_i <= pos;
    write_value_i <= val;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    predicted = apply_request(op, pos, val);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request waiting: removed %h status %0d count %0d",
               removed_value_o, status_o, entry_count_o);
        error_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (removed_value_o !== want.removed) begin
          $error("removed_value: expected %h, actual %h", want.removed, removed_value_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          error_count++;
        end
        if (entry_count_o !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, entry_count_o);
          error_count++;
        end
      end
    end
  end

  // Ends the run if neither side transfers anything for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((start_i === 1'b1 && busy_o === 1'b0) || done_o === 1'b1) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles", IdleLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    list_result_t blank;
    opcode_e      op;
    logic [4:0]   pos;
    logic [31:0]  val;
    int unsigned  insert_pct;
    bit           no_gaps;
    int unsigned  pick;
    int unsigned  directed_count;

    blank = '0;

    // Empty list, both extremes of the word, position beyond the end.
    add_row(OpRemoveLast, 5'd0,  32'h0,         1, 32'h0,         StEmpty, 5'd0);
    add_row(OpRemoveAt,   5'd0,  32'hFFFF_FFFF, 1, 32'h0,         StEmpty, 5'd0);
    add_row(OpRemoveAt,   5'd31, 32'h0,         1, 32'h0,         StEmpty, 5'd0);
    add_row(OpInsert,     5'd31, 32'h7FFF_FFFF, 1, 32'h0,         StDone,  5'd1);
    add_row(OpInsert,     5'd0,  32'h8000_0000, 1, 32'h0,         StDone,  5'd2);
    add_row(OpRemoveAt,   5'd2,  32'h0,         1, 32'h0,         StEmpty, 5'd2);
    add_row(OpRemoveAt,   5'd1,  32'h0,         1, 32'h7FFF_FFFF, StDone,  5'd1);
    add_row(OpRemoveLast, 5'd31, 32'h0,         1, 32'h8000_0000, StDone,  5'd0);
    // Fill the list at assorted positions, then overflow it once.
    add_row(OpInsert, 5'd0,  32'hFFFF_FFFF, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd31, 32'h0000_0000, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd1,  32'h0000_0001, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd15, 32'h8000_0000, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd2,  32'h7FFF_FFFF, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd0,  32'hA5A5_A5A5, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd3,  32'h5A5A_5A5A, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd16, 32'h1234_5678, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd7,  32'hDEAD_BEEF, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd4,  32'h0F0F_0F0F, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd10, 32'hF0F0_F0F0, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd11, 32'h0000_FFFF, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd5,  32'hFFFF_0000, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd8,  32'h3C3C_3C3C, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd13, 32'hC3C3_C3C3, 0, 32'h0, StDone, 5'd0);
    add_row(OpInsert, 5'd14, 32'h1357_9BDF, 0, 32'h0, StDone, 5'd16);
    add_row(OpInsert, 5'd3,  32'h2468_ACE0, 1, 32'h0, StFull, 5'd16);
    directed_count = plan.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      send_request(plan[i].op, plan[i].pos, plan[i].val, $urandom_range(0, 4),
                   plan[i].typed, plan[i].want);
    end

    // Each phase leans toward filling, draining or churning the list, so the
    // count keeps sweeping between empty and full.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case ($urandom_range(0, 3))
        0: insert_pct = 85;
        1: insert_pct = 15;
        2: insert_pct = 50;
        default: insert_pct = 60;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseLen; n++) begin
        if ($urandom_range(0, 99) < insert_pct) op = OpInsert;
        else if ($urandom_range(0, 1) == 0) op = OpRemoveAt;
        else op = OpRemoveLast;
        if ($urandom_range(0, 4) == 0) pos = 5'($urandom);
        else pos = 5'($urandom_range(0, shadow_list.size()));
        pick = $urandom_range(0, 19);
        case (pick)
          0: val = 32'h0;
          1: val = 32'hFFFF_FFFF;
          2: val = 32'h8000_0000;
          3: val = 32'h7FFF_FFFF;
          default: val = $urandom;
        endcase
        send_request(op, pos, val, no_gaps ? 0 : $urandom_range(0, 4), 1'b0, blank);
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      error_count++;
    end

    $display("Ran %0d directed and %0d random requests; %0d results checked.",
             directed_count, NumPhases * PhaseLen, results_seen);
    $display("Inserts %0d, removes %0d, full drops %0d, empty removes %0d, full %0d times.",
             inserts_done, removes_done, full_drops, empty_removes, peak_fill_hits);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
tb/positional_list_engine_test.sv
